### design/psum_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psum_pkg: shared types and constants for the proper divisor sum block
// Holds the field widths, the sequencer state type and the status record of
// the bit-serial arithmetic units.
// ----------------------------------------------------------------------------
package psum_pkg;

   localparam int NUMBER_WIDTH_DEF = 40;
   localparam int SUM_WIDTH        = 43;

   // Sequencer states, one-hot
   typedef enum logic [5:0] {
      S_IDLE     = 6'b000001,
      S_DIV      = 6'b000010,
      S_MUL_POW  = 6'b000100,
      S_MUL_PROD = 6'b001000,
      S_MUL_LAST = 6'b010000,
      S_DONE     = 6'b100000
   } state_type;

   // Status of one serial unit
   typedef struct packed {
      logic busy;
      logic done;
   } unit_sts_type;

endpackage

### design/psum_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psum_req_if / psum_rsp_if: request and response channels
// Valid/ready channels carrying the input number and the divisor sum.
// ----------------------------------------------------------------------------
interface psum_req_if #(
   parameter int NUMBER_WIDTH = psum_pkg::NUMBER_WIDTH_DEF
);
   logic                    valid;
   logic                    ready;
   logic [NUMBER_WIDTH-1:0] number_in;

   modport source (output valid, output number_in, input ready);
   modport sink   (input valid, input number_in, output ready);
endinterface

interface psum_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [psum_pkg::SUM_WIDTH-1:0] divisor_sum;

   modport source (output valid, output divisor_sum, input ready);
   modport sink   (input valid, input divisor_sum, output ready);
endinterface

### design/psum_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psum_div: bit-serial restoring divider
// Produces one quotient bit per cycle; quotient and remainder hold after done.
// ----------------------------------------------------------------------------
module psum_div #(
   parameter int NUMBER_WIDTH = psum_pkg::NUMBER_WIDTH_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [NUMBER_WIDTH-1:0] dividend,
   input  logic [NUMBER_WIDTH-1:0] divisor,
   output logic [NUMBER_WIDTH-1:0] quotient,
   output logic [NUMBER_WIDTH-1:0] remainder,
   output psum_pkg::unit_sts_type  sts
);
   localparam int CW = $clog2(NUMBER_WIDTH + 1);

   logic [NUMBER_WIDTH-1:0] rem_ff, rem_in, quo_ff, quo_in, dvs_ff, dvs_in;
   logic [CW-1:0]           cnt_ff, cnt_in;
   logic                    busy_ff, busy_in, done_ff, done_in;
   logic [NUMBER_WIDTH:0]   trial, diff;

   // One restoring step: shift in next dividend bit, subtract if it fits
   always_comb begin
      trial   = {rem_ff, quo_ff[NUMBER_WIDTH-1]};
      diff    = trial - {1'b0, dvs_ff};
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
         cnt_in  = CW'(NUMBER_WIDTH);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = diff[NUMBER_WIDTH] ? trial[NUMBER_WIDTH-1:0] : diff[NUMBER_WIDTH-1:0];
         quo_in = {quo_ff[NUMBER_WIDTH-2:0], ~diff[NUMBER_WIDTH]};
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
   end

   assign quotient  = quo_ff;
   assign remainder = rem_ff;
   assign sts.busy  = busy_ff;
   assign sts.done  = done_ff;

endmodule

### design/psum_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psum_mul: bit-serial shift-add multiplier
// Multiplies two SUM_WIDTH operands modulo 2^SUM_WIDTH, one multiplier bit
// per cycle, stopping as soon as the remaining multiplier bits are zero.
// ----------------------------------------------------------------------------
module psum_mul (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [psum_pkg::SUM_WIDTH-1:0] op_a,
   input  logic [psum_pkg::SUM_WIDTH-1:0] op_b,
   output logic [psum_pkg::SUM_WIDTH-1:0] product,
   output psum_pkg::unit_sts_type         sts
);
   localparam int SW = psum_pkg::SUM_WIDTH;

   logic [SW-1:0] acc_ff, acc_in, mca_ff, mca_in, mpb_ff, mpb_in;
   logic          busy_ff, busy_in, done_ff, done_in;

   // Add the shifted multiplicand for each set multiplier bit
   always_comb begin
      acc_in  = acc_ff;
      mca_in  = mca_ff;
      mpb_in  = mpb_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         acc_in  = '0;
         mca_in  = op_a;
         mpb_in  = op_b;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (mpb_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            acc_in = mpb_ff[0] ? acc_ff + mca_ff : acc_ff;
            mca_in = {mca_ff[SW-2:0], 1'b0};
            mpb_in = {1'b0, mpb_ff[SW-1:1]};
         end
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      mca_ff <= mca_in;
      mpb_ff <= mpb_in;
   end

   assign product  = acc_ff;
   assign sts.busy = busy_ff;
   assign sts.done = done_ff;

endmodule

### design/proper_divisor_sum.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// proper_divisor_sum: sum of the proper divisors of one integer
// Factors the request by trial division and multiplies the prime-power
// divisor sums, returning sigma(n) - n modulo 2^43.
// ----------------------------------------------------------------------------
// One request is worked at a time. The block tries divisor 2 and then the odd
// divisors 3, 5, 7 and upward until the divisor squared exceeds the unfactored
// rest; each trial is one pass of the bit-serial divider. Every prime power
// found adds a serial multiply and one more division. The inputs 0 and 1
// skip the factoring and return zero.
// The divider sets the rate. A new request is taken once the previous
// response has been handed to the output register.
module proper_divisor_sum #(
   parameter int NUMBER_WIDTH = psum_pkg::NUMBER_WIDTH_DEF
) (
   input  logic          clock,
   input  logic          reset,
   psum_req_if.sink      req_chan,
   psum_rsp_if.source    rsp_chan
);
   localparam int SW = psum_pkg::SUM_WIDTH;
   localparam int NW = NUMBER_WIDTH;

   psum_pkg::state_type    state_ff, state_in;
   psum_pkg::unit_sts_type div_sts, mul_sts;

   logic [NW-1:0] num_ff, num_in, rest_ff, rest_in, dvr_ff, dvr_in;
   logic [SW-1:0] prod_ff, prod_in, term_ff, term_in, pow_ff, pow_in;
   logic [SW-1:0] res_ff, res_in, out_ff, out_in;
   logic          inner_ff, inner_in, out_vld_ff, out_vld_in;
   logic          div_go, mul_go;
   logic [NW-1:0] div_a, quo, rem, dvr_next;
   logic [SW-1:0] mul_a, mul_b, mul_p;

   assign dvr_next = (dvr_ff == NW'(2)) ? NW'(3) : dvr_ff + NW'(2);

   // Sequencer
   always_comb begin
      state_in   = state_ff;
      num_in     = num_ff;
      rest_in    = rest_ff;
      dvr_in     = dvr_ff;
      prod_in    = prod_ff;
      term_in    = term_ff;
      pow_in     = pow_ff;
      res_in     = res_ff;
      inner_in   = inner_ff;
      out_in     = out_ff;
      out_vld_in = out_vld_ff && !rsp_chan.ready;
      div_go     = 1'b0;
      div_a      = rest_ff;
      mul_go     = 1'b0;
      mul_a      = prod_ff;
      mul_b      = term_ff;
      unique case (state_ff)
         psum_pkg::S_IDLE: begin
            if (req_chan.valid) begin
               num_in   = req_chan.number_in;
               rest_in  = req_chan.number_in;
               dvr_in   = NW'(2);
               prod_in  = SW'(1);
               inner_in = 1'b0;
               if (req_chan.number_in <= NW'(1)) begin
                  res_in   = '0;
                  state_in = psum_pkg::S_DONE;
               end else begin
                  div_go   = 1'b1;
                  div_a    = req_chan.number_in;
                  state_in = psum_pkg::S_DIV;
               end
            end
         end
         psum_pkg::S_DIV: begin
            if (div_sts.done) begin
               if (inner_ff) begin
                  if (rem == '0) begin
                     // strip one more factor
                     rest_in  = quo;
                     mul_go   = 1'b1;
                     mul_a    = pow_ff;
                     mul_b    = SW'(dvr_ff);
                     state_in = psum_pkg::S_MUL_POW;
                  end else begin
                     // fold the factor sum into the product
                     inner_in = 1'b0;
                     mul_go   = 1'b1;
                     state_in = psum_pkg::S_MUL_PROD;
                  end
               end else if (dvr_ff > quo) begin
                  if (rest_ff != NW'(1)) begin
                     mul_go   = 1'b1;
                     mul_b    = SW'(rest_ff) + SW'(1);
                     state_in = psum_pkg::S_MUL_LAST;
                  end else begin
                     res_in   = prod_ff - SW'(num_ff);
                     state_in = psum_pkg::S_DONE;
                  end
               end else if (rem == '0) begin
                  inner_in = 1'b1;
                  term_in  = SW'(1);
                  rest_in  = quo;
                  mul_go   = 1'b1;
                  mul_a    = SW'(1);
                  mul_b    = SW'(dvr_ff);
                  state_in = psum_pkg::S_MUL_POW;
               end else begin
                  dvr_in = dvr_next;
                  div_go = 1'b1;
               end
            end
         end
         psum_pkg::S_MUL_POW: begin
            if (mul_sts.done) begin
               pow_in   = mul_p;
               term_in  = term_ff + mul_p;
               div_go   = 1'b1;
               state_in = psum_pkg::S_DIV;
            end
         end
         psum_pkg::S_MUL_PROD: begin
            if (mul_sts.done) begin
               prod_in  = mul_p;
               dvr_in   = dvr_next;
               div_go   = 1'b1;
               state_in = psum_pkg::S_DIV;
            end
         end
         psum_pkg::S_MUL_LAST: begin
            if (mul_sts.done) begin
               res_in   = mul_p - SW'(num_ff);
               state_in = psum_pkg::S_DONE;
            end
         end
         psum_pkg::S_DONE: begin
            // hand off when the output register is free
            if (!out_vld_ff || rsp_chan.ready) begin
               out_in     = res_ff;
               out_vld_in = 1'b1;
               state_in   = psum_pkg::S_IDLE;
            end
         end
         default: state_in = psum_pkg::S_IDLE;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= psum_pkg::S_IDLE;
         out_vld_ff <= 1'b0;
         inner_ff   <= 1'b0;
      end else begin
         state_ff   <= state_in;
         out_vld_ff <= out_vld_in;
         inner_ff   <= inner_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      num_ff  <= num_in;
      rest_ff <= rest_in;
      dvr_ff  <= dvr_in;
      prod_ff <= prod_in;
      term_ff <= term_in;
      pow_ff  <= pow_in;
      res_ff  <= res_in;
      out_ff  <= out_in;
   end

   psum_div #(.NUMBER_WIDTH(NW)) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_go),
      .dividend  (div_a),
      .divisor   (dvr_in),
      .quotient  (quo),
      .remainder (rem),
      .sts       (div_sts)
   );

   psum_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_go),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .product (mul_p),
      .sts     (mul_sts)
   );

   assign req_chan.ready       = (state_ff == psum_pkg::S_IDLE);
   assign rsp_chan.valid       = out_vld_ff;
   assign rsp_chan.divisor_sum = out_ff;

`ifndef ASSERT_OFF
   // The two serial units never run at the same time
   a_units_excl: assert property (@(posedge clock) disable iff (reset)
      !(div_sts.busy && mul_sts.busy))
      else $error("divider and multiplier busy together");

   // Trial divisor is 2 or odd while factoring
   a_dvr_odd: assert property (@(posedge clock) disable iff (reset)
      (state_ff == psum_pkg::S_DIV) |-> (dvr_ff[0] || dvr_ff == NW'(2)))
      else $error("even trial divisor above 2");

   // The unfactored rest never reaches zero
   a_rest_nz: assert property (@(posedge clock) disable iff (reset)
      (state_ff == psum_pkg::S_DIV || state_ff == psum_pkg::S_MUL_POW) |-> rest_ff != '0)
      else $error("rest became zero");

   // A completed division always belongs to the divide state
   a_div_done: assert property (@(posedge clock) disable iff (reset)
      div_sts.done |-> state_ff == psum_pkg::S_DIV)
      else $error("stray divider completion");
`endif

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench for proper_divisor_sum
// Drives numbers over the request channel with random gaps, stalls the
// response channel at random, and compares each divisor sum with a local
// trial-division predictor. A short directed table runs first, then random
// smooth and small numbers that keep the factoring time bounded.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int NW          = psum_pkg::NUMBER_WIDTH_DEF;
   localparam int SUM_WIDTH   = psum_pkg::SUM_WIDTH;
   localparam int RAND_ITEMS  = 100;
   localparam int CYCLE_LIMIT = 20000000;

   typedef struct {
      logic [NW-1:0]        number;
      bit                   typed;
      logic [SUM_WIDTH-1:0] sum;
   } dir_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   psum_req_if #(.NUMBER_WIDTH(NW)) req_chan ();
   psum_rsp_if                      rsp_chan ();

   proper_divisor_sum #(.NUMBER_WIDTH(NW)) u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   logic [SUM_WIDTH-1:0] sum_queue[$];
   int   mismatches = 0;
   int   cycles     = 0;
   bit   quiet_mode = 1'b0;
   int   primes[15] = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37, 41, 43, 47};

   dir_row_type dir_table[18] = '{
      '{40'd0,            1'b1, 43'd0},
      '{40'd1,            1'b1, 43'd0},
      '{40'd2,            1'b1, 43'd1},
      '{40'd3,            1'b1, 43'd1},
      '{40'd4,            1'b1, 43'd3},
      '{40'd6,            1'b1, 43'd6},
      '{40'd28,           1'b1, 43'd28},
      '{40'd9,            1'b0, 43'd0},
      '{40'd12,           1'b0, 43'd0},
      '{40'd97,           1'b1, 43'd1},
      '{40'd496,          1'b1, 43'd496},
      '{40'h80_0000_0000, 1'b1, 43'h7F_FFFF_FFFF},
      '{40'hFF_FFFF_FFFF, 1'b0, 43'd0},
      '{40'h55_5555_5555, 1'b0, 43'd0},
      '{40'd720720,       1'b0, 43'd0},
      '{40'd1048573,      1'b0, 43'd0},
      '{40'd65536,        1'b0, 43'd0},
      '{40'd65535,        1'b0, 43'd0}
   };

   // Sum of proper divisors by trial division, modulo 2^43
   function automatic logic [SUM_WIDTH-1:0] divisor_sum_of(logic [NW-1:0] number);
      longint unsigned n, rest, prod, d, term, power;
      n    = 64'(number);
      rest = n;
      prod = 1;
      d    = 2;
      if (n <= 1) return '0;
      while (d <= rest / d) begin
         if (rest % d == 0) begin
            term  = 1;
            power = 1;
            while (rest % d == 0) begin
               rest  = rest / d;
               power = power * d;
               term  = term + power;
            end
            prod = prod * term;
         end
         d = (d == 2) ? 3 : d + 2;
      end
      if (rest != 1) prod = prod * (rest + 1);
      return SUM_WIDTH'(prod - n);
   endfunction

   // Number built from small primes, so factoring stays short
   function automatic logic [NW-1:0] smooth_number();
      longint unsigned v, p;
      v = 1;
      for (int i = 0; i < 40; i++) begin
         p = 64'(primes[$urandom_range(0, 14)]);
         if (v * p < (64'd1 << NW)) v = v * p;
      end
      return NW'(v);
   endfunction

   // Advance the clock
   always #2 clock = ~clock;

   // Count cycles and stop a hung run
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // Stall the response side at random
   initial begin
      int stall;
      rsp_chan.ready = 1'b0;
      @(posedge clock);
      while (1) begin
         stall = quiet_mode ? 0 : $urandom_range(0, 18);
         if (stall == 0) begin
            rsp_chan.ready <= 1'b1;
            @(posedge clock);
         end else begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(posedge clock);
            rsp_chan.ready <= 1'b1;
            @(posedge clock);
         end
         while (!(rsp_chan.valid && rsp_chan.ready)) @(posedge clock);
      end
   end

   // Check each response against the oldest expected sum
   always @(posedge clock) begin
      logic [SUM_WIDTH-1:0] want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (sum_queue.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected response: divisor_sum=%0d", rsp_chan.divisor_sum);
         end else begin
            want = sum_queue.pop_front();
            if (rsp_chan.divisor_sum !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("divisor_sum mismatch: expected %0d, got %0d",
                           want, rsp_chan.divisor_sum);
            end
         end
      end
   end

   // Send one request and hold it until accepted, then draw the gap
   task automatic send_number(logic [NW-1:0] number, logic [SUM_WIDTH-1:0] want);
      int gap;
      req_chan.valid     <= 1'b1;
      req_chan.number_in <= number;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      sum_queue.insert(sum_queue.size(), want);
      gap = quiet_mode ? 0 : $urandom_range(0, 18);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Stimulus: directed table, then random numbers
   initial begin
      logic [NW-1:0] number;
      int            pick;
      req_chan.valid     = 1'b0;
      req_chan.number_in = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_table[i])
         send_number(dir_table[i].number,
                     dir_table[i].typed ? dir_table[i].sum
                                        : divisor_sum_of(dir_table[i].number));

      for (int i = 0; i < RAND_ITEMS; i++) begin
         quiet_mode = (i / 20) % 3 == 2;
         // Drain everything once before continuing
         if (i == 50) begin
            req_chan.valid <= 1'b0;
            @(posedge clock);
            while (sum_queue.size() != 0) @(posedge clock);
         end
         pick = $urandom_range(0, 9);
         if (pick < 4)
            number = smooth_number();
         else if (pick < 9)
            number = NW'($urandom_range(1, 65535));
         else
            number = NW'($urandom_range(1, 1048575));
         send_number(number, divisor_sum_of(number));
      end
      req_chan.valid <= 1'b0;

      // Drain, then let the block settle
      while (sum_queue.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (mismatches == 0 && sum_queue.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
